FILE: hw/rtl/frame_interval_window_stats_core_assert.svh
// Assertion macros for the frame interval statistics RTL.
// The checks are clocked on clk and held off while rst_n is low.
`ifndef FRAME_INTERVAL_WINDOW_STATS_CORE_ASSERT_SVH
`define FRAME_INTERVAL_WINDOW_STATS_CORE_ASSERT_SVH

// Same-cycle implication: whenever a holds, b holds too.
`define FIWS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("frame interval stats: same-cycle check failed");

// Next-cycle implication: whenever a holds, b holds in the next cycle.
`define FIWS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("frame interval stats: next-cycle check failed");

`endif

FILE: hw/rtl/fiws_pkg.sv
package fiws_pkg;

  // Window depth; it must be a power of two because the mean and the
  // variance divide by it with a shift.
  localparam int HISTORY_DEPTH = 16;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

  localparam int TS_W   = 32;
  localparam int INTV_W = 24;
  localparam int TGT_W  = 20;
  localparam int VAR_W  = 2 * INTV_W;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = INTV_W + HIST_AW;
  localparam int ACC_W  = 2 * INTV_W + HIST_AW;
  localparam int VAR10_W = VAR_W + 4;

  localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(16666);

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WRITE  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CLEAR  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LOOP   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DRAIN1 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DRAIN2 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_VAR    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_STAB   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUT    = 4'd8;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_DISPATCH,
    JMP_LOOP,
    JMP_OUT,
    JMP_GOTO
  } jmp_t;

  typedef struct packed {
    logic              ack;
    logic              wr;
    logic              clr;
    logic              sq;
    logic              drain;
    logic              ld_var;
    logic              ld_stab;
    logic              ld_out;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic acc_frame;
    logic acc_clear;
    logic wr;
    logic clr;
    logic sq;
    logic drain;
    logic ld_var;
    logic ld_stab;
    logic ld_out;
  } fiws_ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic cnt_last;
    logic out_busy;
  } fiws_stat_t;

  function automatic ucw_t fiws_ucode(input logic [STEP_W-1:0] pc);
    ucw_t w;
    w = '{ack: 1'b0, wr: 1'b0, clr: 1'b0, sq: 1'b0, drain: 1'b0, ld_var: 1'b0,
          ld_stab: 1'b0, ld_out: 1'b0, jmp: JMP_NEXT, target: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.ack = 1'b1;
        w.jmp = JMP_DISPATCH;
      end
      STEP_WRITE:  w.wr = 1'b1;
      STEP_CLEAR:  w.clr = 1'b1;
      STEP_LOOP: begin
        w.sq     = 1'b1;
        w.jmp    = JMP_LOOP;
        w.target = STEP_LOOP;
      end
      STEP_DRAIN1: w.drain = 1'b1;
      STEP_DRAIN2: w.drain = 1'b1;
      STEP_VAR:    w.ld_var = 1'b1;
      STEP_STAB:   w.ld_stab = 1'b1;
      STEP_OUT: begin
        w.ld_out = 1'b1;
        w.jmp    = JMP_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/fiws_seq.sv
module fiws_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  input  fiws_pkg::fiws_stat_t stat,
  output logic                ack,
  output fiws_pkg::fiws_ctrl_t ctrl
);
  import fiws_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  ucw_t              cw;
  logic              accept;

  assign cw     = fiws_ucode(pc_r);
  assign ack    = cw.ack;
  assign accept = in_valid && cw.ack;

  always_comb begin
    ctrl.acc_frame = accept && (in_opcode == OP_FRAME);
    ctrl.acc_clear = accept && (in_opcode == OP_CLEAR);
    ctrl.wr        = cw.wr;
    ctrl.clr       = cw.clr;
    ctrl.sq        = cw.sq;
    ctrl.drain     = cw.drain;
    ctrl.ld_var    = cw.ld_var;
    ctrl.ld_stab   = cw.ld_stab;
    // A new result may only be loaded once the output register is free.
    ctrl.ld_out    = cw.ld_out && !stat.out_busy;
  end

  always_comb begin
    case (cw.jmp)
      JMP_NEXT:     pc_nxt = pc_r + 1'b1;
      JMP_DISPATCH: pc_nxt = (accept && (in_opcode == OP_FRAME)) ? pc_r + 1'b1 : pc_r;
      JMP_LOOP:     pc_nxt = stat.cnt_last ? pc_r + 1'b1 : cw.target;
      JMP_OUT:      pc_nxt = stat.out_busy ? pc_r : cw.target;
      JMP_GOTO:     pc_nxt = cw.target;
      default:      pc_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: hw/rtl/fiws_dp.sv
module fiws_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fiws_pkg::fiws_ctrl_t             ctrl,
  output fiws_pkg::fiws_stat_t             stat,
  input  logic [fiws_pkg::TS_W-1:0]        in_timestamp,
  input  logic                             cfg_we,
  input  logic [fiws_pkg::TGT_W-1:0]       cfg_data,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [fiws_pkg::INTV_W-1:0]      out_interval,
  output logic [fiws_pkg::INTV_W-1:0]      out_mean_interval,
  output logic [fiws_pkg::VAR_W-1:0]       out_interval_variance,
  output logic                             out_stable,
  output logic [fiws_pkg::CNT_W-1:0]       out_frame_count
);
  import fiws_pkg::*;

  logic [TGT_W-1:0]         target_r;
  logic [TS_W-1:0]          last_r;
  logic [CNT_W-1:0]         count_r;
  logic [INTV_W-1:0]        ring_r [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic [INTV_W-1:0]        fill_r;
  logic [HIST_AW-1:0]       widx_r;
  logic [HIST_AW-1:0]       cnt_r;
  logic [SUM_W-1:0]         sum_r;
  logic [INTV_W-1:0]        delta_r;
  logic [INTV_W-1:0]        d_r;
  logic [VAR_W-1:0]         prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic [VAR_W-1:0]         var_r;
  logic                     stable_r;
  logic                     out_valid_r;

  logic [TS_W-1:0]    diff;
  logic [INTV_W-1:0]  delta;
  logic [HIST_AW-1:0] rd_addr;
  logic [INTV_W-1:0]  entry;
  logic [INTV_W-1:0]  mean;
  logic [INTV_W-1:0]  absdiff;
  logic [VAR10_W-1:0] var10;

  assign diff  = in_timestamp - last_r;
  assign delta = (|diff[TS_W-1:INTV_W]) ? {INTV_W{1'b1}} : diff[INTV_W-1:0];

  // One read port, shared by the old-entry fetch and the square walk.
  // Entries not written since the last fill read as the fill value.
  assign rd_addr = ctrl.wr ? widx_r : cnt_r;
  assign entry   = valid_r[rd_addr] ? ring_r[rd_addr] : fill_r;
  assign mean    = sum_r[SUM_W-1:HIST_AW];
  assign absdiff = (entry >= mean) ? (entry - mean) : (mean - entry);
  assign var10   = (VAR10_W'(var_r) << 3) + (VAR10_W'(var_r) << 1);

  assign stat.cnt_last = (cnt_r == HIST_AW'(HISTORY_DEPTH - 1));
  assign stat.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RESET;
      last_r      <= '0;
      count_r     <= '0;
      valid_r     <= '0;
      fill_r      <= INTV_W'(TARGET_RESET);
      widx_r      <= '0;
      sum_r       <= SUM_W'(TARGET_RESET) << HIST_AW;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_data;
      end
      if (ctrl.acc_clear) begin
        valid_r <= '0;
        fill_r  <= INTV_W'(target_r);
        sum_r   <= SUM_W'(target_r) << HIST_AW;
        widx_r  <= '0;
        count_r <= '0;
      end
      if (ctrl.acc_frame) begin
        last_r  <= in_timestamp;
        count_r <= count_r + 1'b1;
      end
      if (ctrl.wr) begin
        valid_r[widx_r] <= 1'b1;
        sum_r  <= sum_r - SUM_W'(entry) + SUM_W'(delta_r);
        widx_r <= (widx_r == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : widx_r + 1'b1;
      end
      if (ctrl.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_frame) begin
      delta_r <= delta;
    end
    if (ctrl.wr) begin
      ring_r[widx_r] <= delta_r;
    end
    if (ctrl.clr) begin
      cnt_r  <= '0;
      d_r    <= '0;
      prod_r <= '0;
      acc_r  <= '0;
    end
    if (ctrl.sq || ctrl.drain) begin
      d_r    <= ctrl.sq ? absdiff : '0;
      prod_r <= VAR_W'(d_r) * VAR_W'(d_r);
      acc_r  <= acc_r + ACC_W'(prod_r);
    end
    if (ctrl.sq) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctrl.ld_var) begin
      var_r <= acc_r[ACC_W-1:HIST_AW];
    end
    if (ctrl.ld_stab) begin
      stable_r <= (var10 < VAR10_W'(target_r));
    end
    if (ctrl.ld_out) begin
      out_interval          <= delta_r;
      out_mean_interval     <= mean;
      out_interval_variance <= var_r;
      out_stable            <= stable_r;
      out_frame_count       <= count_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/frame_interval_window_stats_core.sv
// Frame interval window statistics.
// Input channel (in_valid / in_stall, in_opcode, in_timestamp): a transaction with
// opcode frame carries a microsecond timestamp; opcode clear refills the window
// with the target period, zeroes the frame count and produces no result.
// Output channel (out_valid / out_stall): one transaction per frame with the
// interval, window mean, population variance, stable flag and frame count.
// Configuration channel (cfg_valid / cfg_ready, cfg_data): writes the 20-bit
// target period; cfg_ready is always high.
// The interval is taken at the accepting edge; then the write step updates the
// ring and running sum, the clear step clears the square pipe, the loop step
// walks the window entries one per cycle through a shared subtract, square and
// accumulate pipe, and two drain steps and three finish steps follow, the last
// of which loads the result. A clear is complete in the idle step that takes
// it. The next transaction is taken once the sequencer is back at its idle step,
// while the previous result may still wait at the output. If the receiver
// stalls, the result holds in the output register and the sequencer waits at
// its final step only when a second result is ready.
// Synchronous reset returns the target period to 16666, fills the window and
// mean with it, and clears the last timestamp and frame count.
module frame_interval_window_stats_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [fiws_pkg::TS_W-1:0]    in_timestamp,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fiws_pkg::INTV_W-1:0]  out_interval,
  output logic [fiws_pkg::INTV_W-1:0]  out_mean_interval,
  output logic [fiws_pkg::VAR_W-1:0]   out_interval_variance,
  output logic                         out_stable,
  output logic [fiws_pkg::CNT_W-1:0]   out_frame_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fiws_pkg::TGT_W-1:0]   cfg_data
);
  import fiws_pkg::*;

  `include "frame_interval_window_stats_core_assert.svh"

  fiws_ctrl_t ctrl;
  fiws_stat_t stat;
  logic       ack;

  // The target period register accepts a write in any cycle.
  assign cfg_ready = 1'b1;
  // The block takes input transactions only at the sequencer's idle step.
  assign in_stall  = !ack;

  fiws_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .stat      (stat),
    .ack       (ack),
    .ctrl      (ctrl)
  );

  fiws_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .stat                  (stat),
    .in_timestamp          (in_timestamp),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_data              (cfg_data),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_interval          (out_interval),
    .out_mean_interval     (out_mean_interval),
    .out_interval_variance (out_interval_variance),
    .out_stable            (out_stable),
    .out_frame_count       (out_frame_count)
  );

  // A waiting result is never overwritten by the next one.
  `FIWS_ASSERT_IMP(a_no_overwrite, ctrl.ld_out, !(out_valid && out_stall))
  // A frame keeps the block busy in the cycle after it is taken.
  `FIWS_ASSERT_NXT(a_frame_busy, ctrl.acc_frame, in_stall)
  // A clear leaves the block ready again in the cycle after it is taken.
  `FIWS_ASSERT_NXT(a_clear_quick, ctrl.acc_clear, !in_stall)

endmodule
